FILE: sv/bpsd_pkg.sv
// Shared types, codes, CRC and magic-byte helpers for the BPS patch decoder.
package bpsd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [23:0] LEN_MAX  = 24'hFFFFFF;

  // item kinds on the input tuser
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PATCH = 2'd1;
  localparam logic [1:0] FUNC_STEP  = 2'd2;

  // command actions
  localparam logic [1:0] ACT_SRC_READ = 2'd0;
  localparam logic [1:0] ACT_TGT_READ = 2'd1;
  localparam logic [1:0] ACT_SRC_COPY = 2'd2;
  localparam logic [1:0] ACT_TGT_COPY = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_SRC_SIZE = 3'd2;
  localparam logic [2:0] ST_TGT_SIZE = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_SRC_CRC  = 3'd5;
  localparam logic [2:0] ST_PAT_CRC  = 3'd6;
  localparam logic [2:0] ST_TGT_CRC  = 3'd7;

  // config register indexes
  localparam logic [1:0] CFG_SRC_LEN = 2'd0;
  localparam logic [1:0] CFG_TGT_LEN = 2'd1;
  localparam logic [1:0] CFG_PAT_LEN = 2'd2;

  // byte source of a produced target byte
  typedef enum logic [1:0] {
    SEL_LIT,
    SEL_SRC,
    SEL_TGT
  } sel_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] i);
    logic [7:0] m;
    case (i)
      2'd0:    m = 8'h42;
      2'd1:    m = 8'h50;
      2'd2:    m = 8'h53;
      default: m = 8'h31;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/bps_delta_patch_decoder.sv
// BPS delta patch decoder: source/target stores, patch parser, CRC checks.
// Pipeline: two register stages (accept and memory read, then byte select, target write and
// output register). Throughput: one item per cycle when the output is not stalled; copy steps
// read one store port per item, and a target copy of the byte just written is served by a
// forward from the write stage.
// Reset (synchronous, rst_n low) clears parser state, counters, pointers and
// status and sets the CRCs to all ones; the stores are not cleared.
module bps_delta_patch_decoder #(
  parameter int SOURCE_DEPTH     = 65536,
  parameter int TARGET_DEPTH     = 65536,
  parameter int VARINT_MAX_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], source_address[23:8]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_address[15:0], out_byte[23:16], copy_pending[24],
                                  // done_res[25], status[28:26], zero[31:29]
  output logic        out_tuser   // out_valid[0]
);

  localparam int SAW = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
  localparam int TAW = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
  localparam logic [31:0] SD32 = 32'(SOURCE_DEPTH);
  localparam logic [31:0] TD32 = 32'(TARGET_DEPTH);
  localparam logic [3:0]  VMAX = 4'(VARINT_MAX_BYTES);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_SRCSZ, PH_TGTSZ, PH_METASZ, PH_META, PH_CMD,
    PH_OFFSET, PH_LITERAL, PH_DRAIN, PH_SINK, PH_DONE
  } phase_t;

  // config
  logic [16:0] sl_r, tl_r;
  logic [24:0] pl_r;

  // parser state
  phase_t      phase_r, phase_nxt;
  logic [24:0] pcount_r, pcount_nxt;
  logic [31:0] vval_r, vval_nxt;
  logic [5:0]  vshift_r, vshift_nxt;
  logic [3:0]  vbytes_r, vbytes_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [16:0] tp_r, tp_nxt;
  logic [31:0] srp_r, srp_nxt, trp_r, trp_nxt;
  logic [23:0] meta_r, meta_nxt;
  logic [31:0] scrc_r, scrc_nxt, pcrc_r, pcrc_nxt, tcrc_r, tcrc_nxt;
  logic [7:0]  trl_r [12];
  logic [7:0]  trl_nxt [12];
  logic [2:0]  err_r, err_nxt, err_acc;

  // stage 1 (memory read done)
  logic        s1_v_r, s1_wr_r, s1_zero_r, s1_fwd_r, s1_pend_r, s1_done_r, s1_fin_r;
  logic [16:0] s1_waddr_r;
  bpsd_pkg::sel_t s1_sel_r, sel_acc;
  logic [7:0]  s1_lit_r, s1_fwdb_r, s1_byte;
  logic [2:0]  s1_stat_r, s1_fcode_r, fcode_acc, fstat;
  logic        wr_acc, zero_acc, fin_acc, fin_wr, s1_adv;

  // output register
  logic        o_v_r, o_valid_r, o_pend_r, o_done_r;
  logic [15:0] o_addr_r;
  logic [7:0]  o_byte_r;
  logic [2:0]  o_stat_r;

  // memories
  logic [7:0]     src_mem [SOURCE_DEPTH];
  logic [7:0]     tgt_mem [TARGET_DEPTH];
  logic [7:0]     src_q, tgt_q;
  logic           src_we, src_re, tgt_re, tgt_we;
  logic [SAW-1:0] src_wa, src_ra;
  logic [TAW-1:0] tgt_ra, tgt_wa;
  logic [31:0]    src_ra32, tgt_wa32, saddr32, tp32;

  logic        acc;
  logic [1:0]  func;
  logic [7:0]  b;
  logic [15:0] saddr;

  // varint helpers
  logic [31:0] vsum;
  logic        vend;
  logic [6:0]  vtop;

  assign acc   = in_tvalid && in_tready;
  assign func  = in_tuser;
  assign b     = in_tdata[7:0];
  assign saddr = in_tdata[23:8];

  assign s1_adv    = s1_v_r && (!o_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_adv;

  assign saddr32 = {16'b0, saddr};
  assign tp32    = {15'b0, tp_r};
  assign src_wa  = saddr32[SAW-1:0];
  assign src_we  = acc && (func == bpsd_pkg::FUNC_LOAD) && (saddr32 < SD32);

  assign vtop = 7'(vshift_r) + 7'd7;
  assign vsum = vval_r + ({25'b0, b[6:0]} << vshift_r) + (b[7] ? 32'd0 : (32'd1 << vtop));
  assign vend = b[7] || ((vbytes_r + 4'd1) >= VMAX);

  always_comb begin
    logic [24:0] tstart;
    logic [24:0] p;
    logic        wt_ok;
    logic [31:0] len;
    logic [31:0] mag;
    logic [31:0] le_src, le_pat;

    phase_nxt  = phase_r;
    pcount_nxt = pcount_r;
    vval_nxt   = vval_r;
    vshift_nxt = vshift_r;
    vbytes_nxt = vbytes_r;
    act_nxt    = act_r;
    rem_nxt    = rem_r;
    tp_nxt     = tp_r;
    srp_nxt    = srp_r;
    trp_nxt    = trp_r;
    meta_nxt   = meta_r;
    scrc_nxt   = scrc_r;
    pcrc_nxt   = pcrc_r;
    trl_nxt    = trl_r;
    err_acc    = err_r;
    wr_acc     = 1'b0;
    zero_acc   = 1'b0;
    sel_acc    = bpsd_pkg::SEL_LIT;
    fin_acc    = 1'b0;
    fcode_acc  = bpsd_pkg::ST_OK;
    src_re     = 1'b0;
    tgt_re     = 1'b0;
    src_ra32   = tp32;
    tstart     = (pl_r >= 25'd12) ? (pl_r - 25'd12) : 25'd0;
    p          = pcount_r - tstart;
    wt_ok      = (tp_r < tl_r) && (tp32 < TD32);
    len        = {2'b0, vsum[31:2]} + 32'd1;
    mag        = {1'b0, vsum[31:1]};
    le_src     = 32'b0;
    le_pat     = 32'b0;

    if (acc) begin
      case (func)
        bpsd_pkg::FUNC_LOAD: begin
          scrc_nxt = bpsd_pkg::crc_byte(scrc_r, b);
        end
        bpsd_pkg::FUNC_PATCH: begin
          if (phase_r != PH_DONE && phase_r != PH_DRAIN && pcount_r < pl_r) begin
            pcount_nxt = pcount_r + 25'd1;
            if (pl_r >= 25'd4 && pcount_r < pl_r - 25'd4)
              pcrc_nxt = bpsd_pkg::crc_byte(pcrc_r, b);
            if (pcount_r >= tstart) begin
              // trailer region: CRC bytes only
              trl_nxt[p[3:0]] = b;
              if (pcount_nxt == pl_r) begin
                fin_acc   = 1'b1;
                phase_nxt = PH_DONE;
                le_src = {trl_nxt[3], trl_nxt[2], trl_nxt[1], trl_nxt[0]};
                le_pat = {trl_nxt[11], trl_nxt[10], trl_nxt[9], trl_nxt[8]};
                if (phase_r inside {PH_MAGIC, PH_SRCSZ, PH_TGTSZ})
                  fcode_acc = bpsd_pkg::ST_HEADER;
                else if (~scrc_r != le_src)
                  fcode_acc = bpsd_pkg::ST_SRC_CRC;
                else if (~pcrc_nxt != le_pat)
                  fcode_acc = bpsd_pkg::ST_PAT_CRC;
                else if (tp_r != tl_r)
                  fcode_acc = bpsd_pkg::ST_TGT_CRC;
              end
            end else begin
              if (phase_r inside {PH_SRCSZ, PH_TGTSZ, PH_METASZ, PH_CMD, PH_OFFSET}) begin
                vval_nxt = vsum;
                if (vend) begin
                  vshift_nxt = 6'd0;
                  vbytes_nxt = 4'd0;
                end else begin
                  vshift_nxt = vshift_r + 6'd7;
                  vbytes_nxt = vbytes_r + 4'd1;
                end
              end
              case (phase_r)
                PH_MAGIC: begin
                  if (pcount_r > 25'd3 || b != bpsd_pkg::magic_byte(pcount_r[1:0])) begin
                    if (err_acc == bpsd_pkg::ST_OK) err_acc = bpsd_pkg::ST_HEADER;
                    phase_nxt = PH_SINK;
                  end else if (pcount_r == 25'd3) begin
                    phase_nxt = PH_SRCSZ;
                    vval_nxt  = 32'b0;
                  end
                end
                PH_SRCSZ: begin
                  if (vend) begin
                    if (vsum != {15'b0, sl_r}) begin
                      if (err_acc == bpsd_pkg::ST_OK) err_acc = bpsd_pkg::ST_SRC_SIZE;
                      phase_nxt = PH_SINK;
                    end else begin
                      phase_nxt = PH_TGTSZ;
                    end
                    vval_nxt = 32'b0;
                  end
                end
                PH_TGTSZ: begin
                  if (vend) begin
                    if (vsum != {15'b0, tl_r}) begin
                      if (err_acc == bpsd_pkg::ST_OK) err_acc = bpsd_pkg::ST_TGT_SIZE;
                      phase_nxt = PH_SINK;
                    end else begin
                      phase_nxt = PH_METASZ;
                    end
                    vval_nxt = 32'b0;
                  end
                end
                PH_METASZ: begin
                  if (vend) begin
                    meta_nxt  = (vsum > {8'b0, bpsd_pkg::LEN_MAX}) ? bpsd_pkg::LEN_MAX
                                                                   : vsum[23:0];
                    phase_nxt = (vsum == 32'b0) ? PH_CMD : PH_META;
                    vval_nxt  = 32'b0;
                  end
                end
                PH_META: begin
                  meta_nxt = meta_r - 24'd1;
                  if (meta_nxt == 24'd0) phase_nxt = PH_CMD;
                end
                PH_CMD: begin
                  if (vend) begin
                    act_nxt = vsum[1:0];
                    rem_nxt = (len > {8'b0, bpsd_pkg::LEN_MAX}) ? bpsd_pkg::LEN_MAX
                                                                : len[23:0];
                    case (vsum[1:0])
                      bpsd_pkg::ACT_SRC_READ: phase_nxt = PH_DRAIN;
                      bpsd_pkg::ACT_TGT_READ: phase_nxt = PH_LITERAL;
                      default:                phase_nxt = PH_OFFSET;
                    endcase
                    vval_nxt = 32'b0;
                  end
                end
                PH_OFFSET: begin
                  if (vend) begin
                    if (act_r == bpsd_pkg::ACT_SRC_COPY)
                      srp_nxt = vsum[0] ? (srp_r - mag) : (srp_r + mag);
                    else
                      trp_nxt = vsum[0] ? (trp_r - mag) : (trp_r + mag);
                    vval_nxt  = 32'b0;
                    phase_nxt = PH_DRAIN;
                  end
                end
                PH_LITERAL: begin
                  if (!wt_ok) begin
                    if (err_acc == bpsd_pkg::ST_OK) err_acc = bpsd_pkg::ST_OVERFLOW;
                    rem_nxt   = 24'd0;
                    phase_nxt = PH_SINK;
                  end else begin
                    wr_acc  = 1'b1;
                    sel_acc = bpsd_pkg::SEL_LIT;
                    tp_nxt  = tp_r + 17'd1;
                    rem_nxt = rem_r - 24'd1;
                    if (rem_nxt == 24'd0) phase_nxt = PH_CMD;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        bpsd_pkg::FUNC_STEP: begin
          if (phase_r == PH_DRAIN) begin
            if (!wt_ok) begin
              if (err_acc == bpsd_pkg::ST_OK) err_acc = bpsd_pkg::ST_OVERFLOW;
              rem_nxt   = 24'd0;
              phase_nxt = PH_SINK;
            end else begin
              wr_acc = 1'b1;
              tp_nxt = tp_r + 17'd1;
              if (act_r == bpsd_pkg::ACT_TGT_COPY) begin
                sel_acc  = bpsd_pkg::SEL_TGT;
                tgt_re   = 1'b1;
                zero_acc = !(trp_r < TD32);
                trp_nxt  = trp_r + 32'd1;
              end else begin
                sel_acc  = bpsd_pkg::SEL_SRC;
                src_re   = 1'b1;
                src_ra32 = (act_r == bpsd_pkg::ACT_SRC_COPY) ? srp_r : tp32;
                zero_acc = !(src_ra32 < SD32);
                if (act_r == bpsd_pkg::ACT_SRC_COPY) srp_nxt = srp_r + 32'd1;
              end
              rem_nxt = rem_r - 24'd1;
              if (rem_nxt == 24'd0) phase_nxt = PH_CMD;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign src_ra = src_ra32[SAW-1:0];
  assign tgt_ra = trp_r[TAW-1:0];

  // byte of the item in stage 1
  always_comb begin
    case (s1_sel_r)
      bpsd_pkg::SEL_SRC: s1_byte = s1_zero_r ? 8'd0 : src_q;
      bpsd_pkg::SEL_TGT: s1_byte = s1_zero_r ? 8'd0 : (s1_fwd_r ? s1_fwdb_r : tgt_q);
      default:           s1_byte = s1_lit_r;
    endcase
  end

  assign tgt_wa32 = {15'b0, s1_waddr_r};
  assign tgt_wa   = tgt_wa32[TAW-1:0];
  assign tgt_we   = s1_adv && s1_wr_r;
  assign tcrc_nxt = tgt_we ? bpsd_pkg::crc_byte(tcrc_r, s1_byte) : tcrc_r;

  // final target check needs the target CRC after the last written byte
  assign fin_wr = s1_adv && s1_fin_r && (s1_stat_r == bpsd_pkg::ST_OK);
  always_comb begin
    if (s1_fcode_r != bpsd_pkg::ST_OK)
      fstat = s1_fcode_r;
    else if (~tcrc_r != {trl_r[7], trl_r[6], trl_r[5], trl_r[4]})
      fstat = bpsd_pkg::ST_TGT_CRC;
    else
      fstat = bpsd_pkg::ST_OK;
  end
  assign err_nxt = fin_wr ? fstat : err_acc;

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_wa] <= b;
    if (src_re) src_q <= src_mem[src_ra];
  end

  always_ff @(posedge clk) begin
    if (tgt_we) tgt_mem[tgt_wa] <= s1_byte;
    if (tgt_re) tgt_q <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r     <= '0;
      tl_r     <= '0;
      pl_r     <= '0;
      phase_r  <= PH_MAGIC;
      pcount_r <= '0;
      vval_r   <= '0;
      vshift_r <= '0;
      vbytes_r <= '0;
      act_r    <= '0;
      rem_r    <= '0;
      tp_r     <= '0;
      srp_r    <= '0;
      trp_r    <= '0;
      meta_r   <= '0;
      scrc_r   <= '1;
      pcrc_r   <= '1;
      tcrc_r   <= '1;
      for (int i = 0; i < 12; i++) trl_r[i] <= '0;
      err_r    <= bpsd_pkg::ST_OK;
      s1_v_r   <= 1'b0;
      o_v_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bpsd_pkg::CFG_SRC_LEN: sl_r <= cfg_wdata[16:0];
          bpsd_pkg::CFG_TGT_LEN: tl_r <= cfg_wdata[16:0];
          bpsd_pkg::CFG_PAT_LEN: pl_r <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r  <= phase_nxt;
      pcount_r <= pcount_nxt;
      vval_r   <= vval_nxt;
      vshift_r <= vshift_nxt;
      vbytes_r <= vbytes_nxt;
      act_r    <= act_nxt;
      rem_r    <= rem_nxt;
      tp_r     <= tp_nxt;
      srp_r    <= srp_nxt;
      trp_r    <= trp_nxt;
      meta_r   <= meta_nxt;
      scrc_r   <= scrc_nxt;
      pcrc_r   <= pcrc_nxt;
      tcrc_r   <= tcrc_nxt;
      trl_r    <= trl_nxt;
      err_r    <= err_nxt;
      if (acc)         s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (s1_adv)          o_v_r <= 1'b1;
      else if (out_tready) o_v_r <= 1'b0;
    end
  end

  // stage 1 and output payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_wr_r    <= wr_acc;
      s1_waddr_r <= tp_r;
      s1_sel_r   <= sel_acc;
      s1_zero_r  <= zero_acc;
      s1_lit_r   <= b;
      // the item ahead writes the target store at this same edge
      s1_fwd_r   <= s1_v_r && s1_wr_r && (tgt_wa == tgt_ra);
      s1_fwdb_r  <= s1_byte;
      s1_pend_r  <= (phase_nxt == PH_DRAIN);
      s1_done_r  <= (phase_nxt == PH_DONE);
      s1_stat_r  <= err_nxt;
      s1_fin_r   <= fin_acc;
      s1_fcode_r <= fcode_acc;
    end
    if (s1_adv) begin
      o_valid_r <= s1_wr_r;
      o_addr_r  <= s1_wr_r ? s1_waddr_r[15:0] : 16'd0;
      o_byte_r  <= s1_wr_r ? s1_byte : 8'd0;
      o_pend_r  <= s1_pend_r;
      o_done_r  <= s1_done_r;
      o_stat_r  <= fin_wr ? fstat : s1_stat_r;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tuser  = o_valid_r;
  assign out_tdata  = {3'b0, o_stat_r, o_done_r, o_pend_r, o_byte_r, o_addr_r};

  a_pend_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[24] && out_tdata[25]))
    else $error("copy pending and done together");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[23:0] == 24'd0))
    else $error("payload set without a produced byte");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_waddr_r) && $stable(s1_stat_r)))
    else $error("stalled stage 1 item lost");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the BPS delta patch decoder stream interface.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [1:0] CFG_NONE  = 2'd3;
  localparam int unsigned SRC_IMG_BYTES = 512;
  localparam int unsigned ITEM_GOAL = 1500;

  typedef enum logic [3:0] {
    PS_MAGIC, PS_SRCSZ, PS_TGTSZ, PS_METASZ, PS_META, PS_CMD,
    PS_OFFSET, PS_LITERAL, PS_DRAIN, PS_SINK, PS_DONE
  } phase_t;

  typedef struct packed {
    logic        ovalid;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        pend;
    logic        done;
    logic [2:0]  status;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [24:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // data_byte[7:0], source_address[23:8]
  logic [1:0]  in_tuser = '0;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // addr[15:0], byte[23:16], pend[24], done[25], status[28:26]
  logic        out_tuser;       // out_valid[0]

  bps_delta_patch_decoder u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder shadow state
  bit [7:0]    src_img [65536];
  bit [7:0]    tgt_img [65536];
  int unsigned src_len, tgt_len, pat_len;
  phase_t      phase;
  int unsigned pat_count, vint, vshift, vbytes, remain, tptr, srel, trel, meta_left;
  logic [1:0]  action;
  logic [31:0] src_crc, pat_crc, tgt_crc;
  bit [7:0]    trailer [12];
  logic [2:0]  err;

  result_t     expected_q [$];
  int          errors = 0;
  int unsigned items_sent = 0;
  int          burst_left = 0;
  int          hold_len = 0;

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ bpsd_pkg::CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void flag(logic [2:0] code);
    if (err == bpsd_pkg::ST_OK) err = code;
  endfunction

  function automatic bit vint_feed(logic [7:0] b);
    logic [63:0] v;
    v = 64'(vint) + (64'(b[6:0]) << vshift);
    vbytes++;
    if (!b[7]) v += 64'd1 << (vshift + 7);
    vint = v[31:0];
    if (b[7] || vbytes >= 8) begin
      vshift = 0;
      vbytes = 0;
      return 1'b1;
    end
    vshift += 7;
    return 1'b0;
  endfunction

  function automatic bit put_target(logic [7:0] b, inout result_t r);
    if (tptr >= tgt_len || tptr >= 65536) begin
      flag(bpsd_pkg::ST_OVERFLOW);
      remain = 0;
      phase = PS_SINK;
      return 1'b0;
    end
    tgt_img[tptr] = b;
    tgt_crc = crc_step(tgt_crc, b);
    r.ovalid = 1'b1;
    r.addr = tptr[15:0];
    r.data = b;
    tptr = (tptr + 1) & 32'h1FFFF;
    return 1'b1;
  endfunction

  function automatic logic [31:0] trailer_word(int at);
    return {trailer[at+3], trailer[at+2], trailer[at+1], trailer[at]};
  endfunction

  function automatic void close_patch();
    phase_t ph;
    ph = phase;
    phase = PS_DONE;
    if (err != bpsd_pkg::ST_OK) return;
    if (ph == PS_MAGIC || ph == PS_SRCSZ || ph == PS_TGTSZ) err = bpsd_pkg::ST_HEADER;
    else if (~src_crc != trailer_word(0)) err = bpsd_pkg::ST_SRC_CRC;
    else if (~pat_crc != trailer_word(8)) err = bpsd_pkg::ST_PAT_CRC;
    else if (tptr != tgt_len || ~tgt_crc != trailer_word(4)) err = bpsd_pkg::ST_TGT_CRC;
  endfunction

  function automatic void take_patch_byte(logic [7:0] b, inout result_t r);
    int unsigned idx, tstart, len;
    logic [7:0] magic [4];
    magic = '{8'h42, 8'h50, 8'h53, 8'h31};
    idx = pat_count;
    tstart = pat_len >= 12 ? pat_len - 12 : 0;
    if (phase == PS_DONE || phase == PS_DRAIN || idx >= pat_len) return;
    pat_count = idx + 1;
    if (pat_len >= 4 && idx < pat_len - 4) pat_crc = crc_step(pat_crc, b);
    if (idx >= tstart) begin
      if (idx - tstart < 12) trailer[idx - tstart] = b;
      if (pat_count == pat_len) close_patch();
      return;
    end
    case (phase)
      PS_MAGIC: begin
        if (idx > 3 || b != magic[idx & 3]) begin
          flag(bpsd_pkg::ST_HEADER);
          phase = PS_SINK;
        end else if (idx == 3) begin
          phase = PS_SRCSZ;
          vint = 0;
        end
      end
      PS_SRCSZ, PS_TGTSZ: begin
        if (vint_feed(b)) begin
          if (phase == PS_SRCSZ) begin
            if (vint != src_len) begin flag(bpsd_pkg::ST_SRC_SIZE); phase = PS_SINK; end
            else phase = PS_TGTSZ;
          end else begin
            if (vint != tgt_len) begin flag(bpsd_pkg::ST_TGT_SIZE); phase = PS_SINK; end
            else phase = PS_METASZ;
          end
          vint = 0;
        end
      end
      PS_METASZ: begin
        if (vint_feed(b)) begin
          meta_left = vint > bpsd_pkg::LEN_MAX ? bpsd_pkg::LEN_MAX : vint;
          phase = meta_left == 0 ? PS_CMD : PS_META;
          vint = 0;
        end
      end
      PS_META: begin
        meta_left--;
        if (meta_left == 0) phase = PS_CMD;
      end
      PS_CMD: begin
        if (vint_feed(b)) begin
          len = (vint >> 2) + 1;
          action = vint[1:0];
          remain = len > bpsd_pkg::LEN_MAX ? bpsd_pkg::LEN_MAX : len;
          case (action)
            bpsd_pkg::ACT_SRC_READ: phase = PS_DRAIN;
            bpsd_pkg::ACT_TGT_READ: phase = PS_LITERAL;
            default:                phase = PS_OFFSET;
          endcase
          vint = 0;
        end
      end
      PS_OFFSET: begin
        if (vint_feed(b)) begin
          if (action == bpsd_pkg::ACT_SRC_COPY)
            srel = vint[0] ? srel - (vint >> 1) : srel + (vint >> 1);
          else
            trel = vint[0] ? trel - (vint >> 1) : trel + (vint >> 1);
          vint = 0;
          phase = PS_DRAIN;
        end
      end
      PS_LITERAL: begin
        if (put_target(b, r)) begin
          remain--;
          if (remain == 0) phase = PS_CMD;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void take_step(inout result_t r);
    logic [7:0] b;
    if (phase != PS_DRAIN) return;
    if (action == bpsd_pkg::ACT_SRC_READ)      b = tptr < 65536 ? src_img[tptr] : 8'h00;
    else if (action == bpsd_pkg::ACT_SRC_COPY) b = srel < 65536 ? src_img[srel] : 8'h00;
    else                                       b = trel < 65536 ? tgt_img[trel] : 8'h00;
    if (!put_target(b, r)) return;
    if (action == bpsd_pkg::ACT_SRC_COPY) srel++;
    else if (action == bpsd_pkg::ACT_TGT_COPY) trel++;
    remain--;
    if (remain == 0) phase = PS_CMD;
  endfunction

  function automatic void predict_item(logic [1:0] f, logic [7:0] d, logic [15:0] a);
    result_t r;
    r = '0;
    case (f)
      bpsd_pkg::FUNC_LOAD: begin
        src_img[a] = d;
        src_crc = crc_step(src_crc, d);
      end
      bpsd_pkg::FUNC_PATCH: take_patch_byte(d, r);
      bpsd_pkg::FUNC_STEP:  take_step(r);
      default: ;
    endcase
    r.pend = phase == PS_DRAIN;
    r.done = phase == PS_DONE;
    r.status = err;
    expected_q.push_back(r);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker and receiver stall pattern
  int stall_pct = 0;
  int stall_age = 0;
  always @(posedge clk) begin
    result_t w;
    if (out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report("unexpected item", out_tdata, 0);
      end else begin
        w = expected_q.pop_front();
        if (out_tuser !== w.ovalid)        report("out_valid", out_tuser, w.ovalid);
        if (out_tdata[15:0] !== w.addr)    report("out_address", out_tdata[15:0], w.addr);
        if (out_tdata[23:16] !== w.data)   report("out_byte", out_tdata[23:16], w.data);
        if (out_tdata[24] !== w.pend)      report("copy_pending", out_tdata[24], w.pend);
        if (out_tdata[25] !== w.done)      report("done", out_tdata[25], w.done);
        if (out_tdata[28:26] !== w.status) report("status", out_tdata[28:26], w.status);
      end
    end
    if (++stall_age >= 64) begin
      stall_age = 0;
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
    end
    if (hold_len > 0) begin
      hold_len--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  task automatic send_item(logic [1:0] f, logic [7:0] d, logic [15:0] a);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {a, d};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(f, d, a);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [24:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bpsd_pkg::CFG_SRC_LEN: src_len = v & 25'h1FFFF;
      bpsd_pkg::CFG_TGT_LEN: tgt_len = v & 25'h1FFFF;
      bpsd_pkg::CFG_PAT_LEN: pat_len = v;
      default: ;
    endcase
  endtask

  task automatic send_patch(logic [7:0] b);
    send_item(bpsd_pkg::FUNC_PATCH, b, 16'($urandom));
  endtask

  // BPS varint: low 7 bits per byte, top bit marks the last byte
  task automatic send_varint(int unsigned v);
    int unsigned x;
    forever begin
      x = v & 32'h7F;
      v = v >> 7;
      if (v == 0) begin
        send_patch(8'(x | 32'h80));
        break;
      end
      send_patch(8'(x));
      v--;
    end
  endtask

  task automatic drain_copy();
    while (phase == PS_DRAIN) begin
      case ($urandom_range(0, 9))
        0: send_patch(8'($urandom));  // dropped while a copy is pending
        1: send_item(FUNC_NONE, 8'($urandom), 16'($urandom));
        default: send_item(bpsd_pkg::FUNC_STEP, 8'($urandom), 16'($urandom));
      endcase
    end
  endtask

  task automatic issue_cmd(logic [1:0] act, int unsigned len, int unsigned at);
    int delta;
    send_varint(((len - 1) << 2) | act);
    if (act == bpsd_pkg::ACT_TGT_READ) begin
      repeat (len) send_patch(8'($urandom));
    end else begin
      if (act == bpsd_pkg::ACT_SRC_COPY || act == bpsd_pkg::ACT_TGT_COPY) begin
        delta = int'(at) - int'(act == bpsd_pkg::ACT_SRC_COPY ? srel : trel);
        send_varint(delta < 0 ? ((-delta) << 1) | 1 : delta << 1);
      end
      drain_copy();
    end
  endtask

  task automatic random_cmd();
    int unsigned len;
    len = $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0: if (tptr + len <= SRC_IMG_BYTES) issue_cmd(bpsd_pkg::ACT_SRC_READ, len, 0);
         else issue_cmd(bpsd_pkg::ACT_TGT_READ, len, 0);
      1: issue_cmd(bpsd_pkg::ACT_TGT_READ, len, 0);
      2: issue_cmd(bpsd_pkg::ACT_SRC_COPY, len, $urandom_range(0, SRC_IMG_BYTES - len));
      default: issue_cmd(bpsd_pkg::ACT_TGT_COPY, len, $urandom_range(0, tptr - 1));
    endcase
  endtask

  task automatic test_idle_items();
    // nothing pending, patch length zero: patch bytes and steps do nothing
    send_item(bpsd_pkg::FUNC_STEP, 8'hFF, 16'hFFFF);
    send_patch(8'h42);
    send_patch(8'h00);
    send_item(FUNC_NONE, 8'hFF, 16'hFFFF);
    send_item(bpsd_pkg::FUNC_STEP, 8'h00, 16'h0000);
  endtask

  task automatic test_source_load();
    send_item(bpsd_pkg::FUNC_LOAD, 8'hFF, 16'hFFFF);
    send_item(bpsd_pkg::FUNC_LOAD, 8'h00, 16'h8000);
    for (int unsigned i = 0; i < SRC_IMG_BYTES; i++)
      send_item(bpsd_pkg::FUNC_LOAD, (i < 2) ? (i == 0 ? 8'h00 : 8'hFF) : 8'($urandom),
                16'(i));
  endtask

  task automatic test_header();
    wait_drained();
    cfg_write(bpsd_pkg::CFG_SRC_LEN, 25'(SRC_IMG_BYTES));
    cfg_write(bpsd_pkg::CFG_TGT_LEN, 25'h10000);
    cfg_write(bpsd_pkg::CFG_PAT_LEN, 25'h1000000);
    cfg_write(CFG_NONE, 25'h1FFFFFF);
    send_patch(8'h42);
    send_patch(8'h50);
    send_patch(8'h53);
    send_patch(8'h31);
    send_varint(SRC_IMG_BYTES);
    send_varint(32'h10000);
    send_varint(3);
    repeat (3) send_patch(8'($urandom));
  endtask

  task automatic test_each_command();
    issue_cmd(bpsd_pkg::ACT_SRC_READ, 1, 0);
    issue_cmd(bpsd_pkg::ACT_TGT_READ, 2, 0);
    issue_cmd(bpsd_pkg::ACT_SRC_COPY, 3, SRC_IMG_BYTES - 3);
    issue_cmd(bpsd_pkg::ACT_SRC_COPY, 2, 1);          // negative offset
    issue_cmd(bpsd_pkg::ACT_TGT_COPY, 4, tptr - 1);   // overlapping, reads the byte just written
    issue_cmd(bpsd_pkg::ACT_TGT_COPY, 1, 0);
  endtask

  task automatic test_random_stream();
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(bpsd_pkg::FUNC_STEP, 8'($urandom), 16'($urandom));
          1: send_item(FUNC_NONE, 8'($urandom), 16'($urandom));
          default: send_item(bpsd_pkg::FUNC_LOAD, 8'($urandom), 16'($urandom));
        endcase
      end
      random_cmd();
    end
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    issue_cmd(bpsd_pkg::ACT_TGT_READ, 40, 0);
    issue_cmd(bpsd_pkg::ACT_SRC_COPY, 32, 0);
    wait_drained();
    // the source length register no longer matters mid-patch; written with 0 and then 0x10000
    cfg_write(bpsd_pkg::CFG_SRC_LEN, 25'h0);
    cfg_write(bpsd_pkg::CFG_SRC_LEN, 25'h10000);
    repeat (30) random_cmd();
  endtask

  task automatic test_trailer();
    logic [31:0] w;
    wait_drained();
    cfg_write(bpsd_pkg::CFG_TGT_LEN, 25'(tptr));
    cfg_write(bpsd_pkg::CFG_PAT_LEN, 25'(pat_count + 12));
    w = ~src_crc;
    for (int i = 0; i < 4; i++) send_patch(w[8*i +: 8]);
    w = ~tgt_crc;
    for (int i = 0; i < 4; i++) send_patch(w[8*i +: 8]);
    w = ~pat_crc;
    for (int i = 0; i < 4; i++) send_patch(w[8*i +: 8]);
    // after the end patch bytes and steps are ignored; a load still writes the source store
    send_patch(8'h42);
    send_item(bpsd_pkg::FUNC_STEP, 8'h00, 16'h0000);
    send_item(bpsd_pkg::FUNC_LOAD, 8'h5A, 16'h0100);
  endtask

  initial begin
    src_len = 0; tgt_len = 0; pat_len = 0;
    phase = PS_MAGIC;
    pat_count = 0; vint = 0; vshift = 0; vbytes = 0; remain = 0;
    tptr = 0; srel = 0; trel = 0; meta_left = 0; action = bpsd_pkg::ACT_SRC_READ;
    src_crc = '1; pat_crc = '1; tgt_crc = '1; err = bpsd_pkg::ST_OK;
    foreach (trailer[i]) trailer[i] = 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_items();
    test_source_load();
    test_header();
    test_each_command();
    test_random_stream();
    test_backpressure();
    test_trailer();
    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_q.size() != 0) $display("%0d results never arrived", expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout at %0t", $realtime);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: filelist.f
sv/bpsd_pkg.sv
sv/bps_delta_patch_decoder.sv
verif/tb_top.sv
